### sv/miu_pkg.sv
// ----------------------------------------------------------------------------
// miu_pkg
// Shared widths and controller/datapath interface types of the modular
// inverse unit.
// ----------------------------------------------------------------------------
package miu_pkg;

    // signed datapath width; operands use its low WIDTH-1 bits
    localparam int WIDTH   = 32;
    // width of the value, modulus and inverse fields
    localparam int FIELD_W = 31;
    // operand width actually used by the datapath
    localparam int OP_W    = (WIDTH - 1 >= FIELD_W) ? FIELD_W : WIDTH - 1;
    // signed coefficient width
    localparam int CW      = OP_W + 1;
    // divider step counter width (counts 0 .. OP_W-1)
    localparam int CNT_W   = $clog2(OP_W);

    // controller to datapath
    typedef struct packed {
        logic load;       // latch a new input beat
        logic div_step;   // one restoring division step
        logic advance;    // shift remainder sequence, restart divider
        logic coef_init;  // with advance: coefficients to 0 / 1
        logic mul;        // register quotient times current coefficient
        logic mark_fail;  // no inverse, trivial case
        logic out_load;   // write the result register
    } miu_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic mod_small;  // modulus below two
        logic rem_zero;   // divider remainder is zero
        logic out_free;   // result register can take a new beat
    } miu_status_t;

endpackage

### sv/miu_datapath.sv
// ----------------------------------------------------------------------------
// miu_datapath
// Remainder sequence, restoring divider, coefficient update and result
// register of the modular inverse unit.
// ----------------------------------------------------------------------------
module miu_datapath
    import miu_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  miu_cmd_t           cmd,
    output miu_status_t        status,
    input  logic [FIELD_W-1:0] value,
    input  logic [FIELD_W-1:0] modulus,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [FIELD_W-1:0] inverse,
    output logic               no_inverse
);

    logic [OP_W-1:0]        m_reg;
    logic [OP_W-1:0]        num_reg;
    logic [OP_W-1:0]        den_reg;
    logic [OP_W-1:0]        q_reg;
    logic [OP_W-1:0]        r_reg;
    logic                   fail_reg;
    logic signed [CW-1:0]   coef_prev_reg;
    logic signed [CW-1:0]   coef_cur_reg;
    logic signed [CW-1:0]   prod_reg;
    logic                   out_valid_reg;
    logic [FIELD_W-1:0]     inv_reg;
    logic                   flag_reg;

    logic [OP_W:0]          trial;
    logic [OP_W:0]          diff;
    logic signed [2*CW-1:0] mul_full;
    logic signed [CW-1:0]   adj;
    logic [OP_W-1:0]        inv_op;
    logic                   ok;

    // restoring division: bring down next dividend bit, try subtract
    assign trial    = {r_reg, q_reg[OP_W-1]};
    assign diff     = trial - {1'b0, den_reg};
    assign mul_full = $signed({1'b0, q_reg}) * coef_cur_reg;

    // final fix-up of a negative coefficient
    assign adj    = coef_prev_reg + $signed({1'b0, m_reg});
    assign inv_op = coef_prev_reg[CW-1] ? adj[OP_W-1:0] : coef_prev_reg[OP_W-1:0];
    assign ok     = !fail_reg && (num_reg == OP_W'(1));

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_reg    <= modulus[OP_W-1:0];
            den_reg  <= modulus[OP_W-1:0];
            q_reg    <= value[OP_W-1:0];
            r_reg    <= '0;
            fail_reg <= 1'b0;
        end
        if (cmd.div_step) begin
            if (!diff[OP_W]) begin
                r_reg <= diff[OP_W-1:0];
                q_reg <= {q_reg[OP_W-2:0], 1'b1};
            end else begin
                r_reg <= trial[OP_W-1:0];
                q_reg <= {q_reg[OP_W-2:0], 1'b0};
            end
        end
        if (cmd.mul) begin
            prod_reg <= mul_full[CW-1:0];
        end
        if (cmd.advance) begin
            num_reg <= den_reg;
            den_reg <= r_reg;
            q_reg   <= den_reg;
            r_reg   <= '0;
            if (cmd.coef_init) begin
                coef_prev_reg <= '0;
                coef_cur_reg  <= CW'(1);
            end else begin
                coef_prev_reg <= coef_cur_reg;
                coef_cur_reg  <= coef_prev_reg - prod_reg;
            end
        end
        if (cmd.mark_fail) begin
            fail_reg <= 1'b1;
        end
        if (cmd.out_load) begin
            inv_reg  <= ok ? FIELD_W'(inv_op) : '0;
            flag_reg <= !ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.mod_small = (m_reg < OP_W'(2));
    assign status.rem_zero  = (r_reg == '0);
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid   = out_valid_reg;
    assign inverse    = inv_reg;
    assign no_inverse = flag_reg;

endmodule

### sv/miu_ctrl.sv
// ----------------------------------------------------------------------------
// miu_ctrl
// Sequencer of the modular inverse unit: reduction division, Euclid steps
// (divide, multiply, update) and result hand-off.
// ----------------------------------------------------------------------------
module miu_ctrl
    import miu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  miu_status_t status,
    output miu_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED,
        ST_CHK,
        ST_DIV,
        ST_MUL,
        ST_UPD,
        ST_FIN
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             cnt_last;

    assign cnt_last = (cnt_reg == CNT_W'(OP_W - 1));

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_RED;
                end
            end
            ST_RED: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_last) begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                if (status.mod_small || status.rem_zero) begin
                    cmd.mark_fail = 1'b1;
                    state_next    = ST_FIN;
                end else begin
                    cmd.advance   = 1'b1;
                    cmd.coef_init = 1'b1;
                    cnt_next      = '0;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_last) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                cmd.advance = 1'b1;
                cnt_next    = '0;
                state_next  = status.rem_zero ? ST_FIN : ST_DIV;
            end
            ST_FIN: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

### sv/modular_inverse_unit.sv
// ----------------------------------------------------------------------------
// modular_inverse_unit
// Modular inverse by the extended Euclidean algorithm, one beat at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat on s_*: value and modulus. Output beat on m_*: the inverse
//   in m_tdata and the no_inverse flag in m_tuser. One output beat per
//   input beat, in order.
//   The value is first reduced modulo the modulus, then each Euclid step
//   runs a bit-serial restoring division, a multiply step and an update
//   step, until the remainder is zero. A zero value, a multiple of the
//   modulus or a modulus below two ends after the reduction check.
//   The shared divider sets the rate: one beat in flight at a time.
//   no_inverse is raised, with the inverse at zero, when the gcd is not
//   one or when the modulus is below two.
//   s_tready is high only while the sequencer is idle; a finished result
//   sits in the output register, so the next beat is taken while the
//   receiver stalls. A second result waits in the final state until the
//   output register is free.
//   Reset (aresetn low, synchronous) returns the sequencer to idle and
//   drops m_tvalid; no other state survives between beats.
// ----------------------------------------------------------------------------
module modular_inverse_unit
    import miu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [30:0] value, [61:31] modulus, rest zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [30:0] inverse, [31] zero
    output logic [0:0]  m_tuser    // [0] no_inverse
);

    miu_cmd_t           cmd;
    miu_status_t        status;
    logic [FIELD_W-1:0] value;
    logic [FIELD_W-1:0] modulus;
    logic [FIELD_W-1:0] inverse;
    logic               no_inverse;

    // unpack the input beat
    assign value   = s_tdata[FIELD_W-1:0];
    assign modulus = s_tdata[2*FIELD_W-1:FIELD_W];

    miu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    miu_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .value      (value),
        .modulus    (modulus),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .inverse    (inverse),
        .no_inverse (no_inverse)
    );

    // pack the output beat
    assign m_tdata    = {1'b0, inverse};
    assign m_tuser[0] = no_inverse;

    // result register is never overwritten while a beat is still pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("result written while output beat pending");

    // one beat in flight: busy right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while busy");

    // a flagged result carries a zero inverse
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("no_inverse set with nonzero inverse");

endmodule
